[sv/sxfr_pkg.sv]
`timescale 1ns / 1ps

package sxfr_pkg;

   localparam logic [7:0]  SYNC_FIRST          = 8'hEF;
   localparam logic [7:0]  SYNC_SECOND         = 8'hAA;
   localparam logic [15:0] DEFAULT_MAX_PAYLOAD = 16'd1024;

   // Meaning of a result word.
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_GOOD      = 2'd1,
      KIND_BAD_CHECK = 2'd2,
      KIND_TOO_LONG  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  msg_id;
      logic [15:0] frame_size;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic        last;
   } rsp_type;

endpackage

[sv/sxfr_ifs.sv]
`timescale 1ns / 1ps

interface sxfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sxfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  msg_id;
   logic [15:0] frame_size;
   logic [7:0]  data_byte;
   logic [15:0] byte_index;
   logic        last;

   modport source (output valid, output kind, output msg_id, output frame_size,
                   output data_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input kind, input msg_id, input frame_size,
                   input data_byte, input byte_index, input last, output ready);
endinterface

interface sxfr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload;

   modport source (output valid, output max_payload, input ready);
   modport sink   (input valid, input max_payload, output ready);
endinterface

[sv/sxfr_in_reg.sv]
`timescale 1ns / 1ps

module sxfr_in_reg (
   input  logic       clock,
   input  logic       reset,
   sxfr_req_if.sink   req,
   input  logic       drain,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import sxfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   // Space is free when empty or when the held word leaves this cycle.
   assign req.ready = !valid_ff || drain;

   always_comb begin
      valid_in = valid_ff;
      if (req.ready) begin
         valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req.valid && req.ready) begin
         data_ff <= req.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

[sv/sxfr_parse.sv]
`timescale 1ns / 1ps

module sxfr_parse (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  logic            csr_write,
   input  logic [15:0]     csr_data,
   output logic            res_valid,
   output sxfr_pkg::rsp_type res
);
   import sxfr_pkg::*;

   typedef enum logic [2:0] {
      PH_SYNC0   = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_ID      = 3'd2,
      PH_SIZE_HI = 3'd3,
      PH_SIZE_LO = 3'd4,
      PH_DATA    = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] max_ff;
   logic [15:0] size_full;
   logic [15:0] count_inc;
   logic        has_result;

   assign size_full = {size_ff[15:8], rx_byte};
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      check_in       = check_ff;
      id_in          = id_ff;
      size_in        = size_ff;
      count_in       = count_ff;
      has_result     = 1'b0;
      res.kind       = KIND_DATA;
      res.msg_id     = id_ff;
      res.frame_size = size_ff;
      res.data_byte  = 8'd0;
      res.byte_index = 16'd0;
      res.last       = 1'b0;
      case (phase_ff)
         PH_SYNC1: begin
            // A wrong second byte is not retried as a first sync byte.
            phase_in = (rx_byte == SYNC_SECOND) ? PH_ID : PH_SYNC0;
         end
         PH_ID: begin
            id_in    = rx_byte;
            check_in = rx_byte;
            phase_in = PH_SIZE_HI;
         end
         PH_SIZE_HI: begin
            size_in  = {rx_byte, 8'd0};
            check_in = check_ff ^ rx_byte;
            phase_in = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            size_in  = size_full;
            check_in = check_ff ^ rx_byte;
            count_in = 16'd0;
            if (size_full > max_ff) begin
               has_result     = 1'b1;
               res.kind       = KIND_TOO_LONG;
               res.frame_size = size_full;
               res.last       = 1'b1;
               phase_in       = PH_SYNC0;
            end else if (size_full == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            check_in       = check_ff ^ rx_byte;
            has_result     = 1'b1;
            res.data_byte  = rx_byte;
            res.byte_index = count_ff;
            count_in       = count_inc;
            if (count_inc >= size_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            has_result = 1'b1;
            res.kind   = (rx_byte == check_ff) ? KIND_GOOD : KIND_BAD_CHECK;
            res.last   = 1'b1;
            phase_in   = PH_SYNC0;
         end
         default: begin
            // Hunt for the first sync byte; unused codes land here too.
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_SYNC1;
               check_in = 8'd0;
               count_in = 16'd0;
            end else begin
               phase_in = PH_SYNC0;
            end
         end
      endcase
   end

   assign res_valid = step && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC0;
         check_ff <= 8'd0;
         id_ff    <= 8'd0;
         size_ff  <= 16'd0;
         count_ff <= 16'd0;
         max_ff   <= DEFAULT_MAX_PAYLOAD;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            check_ff <= check_in;
            id_ff    <= id_in;
            size_ff  <= size_in;
            count_ff <= count_in;
         end
         if (csr_write) begin
            max_ff <= csr_data;
         end
      end
   end

   a_count_below_size: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> count_ff < size_ff)
      else $error("payload count reached declared size inside the data phase");

   a_check_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CHECK |=> phase_ff == PH_SYNC0)
      else $error("checksum byte did not end the frame");

   a_too_long_is_over_limit: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_TOO_LONG |-> res.frame_size > max_ff)
      else $error("length error raised for a size within the limit");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_DATA |-> res.byte_index < res.frame_size && !res.last)
      else $error("payload word outside its declared frame");

endmodule

[sv/sxfr_out_reg.sv]
`timescale 1ns / 1ps

module sxfr_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  sxfr_pkg::rsp_type load_data,
   output logic              free,
   sxfr_rsp_if.source        rsp
);
   import sxfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (free && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.kind       = data_ff.kind;
   assign rsp.msg_id     = data_ff.msg_id;
   assign rsp.frame_size = data_ff.frame_size;
   assign rsp.data_byte  = data_ff.data_byte;
   assign rsp.byte_index = data_ff.byte_index;
   assign rsp.last       = data_ff.last;

endmodule

[sv/sync_length_xor_frame_receiver.sv]
`timescale 1ns / 1ps

// Frame receiver for a byte stream from a serial link. It hunts for the sync
// pair 0xEF 0xAA, then reads a message id, a big-endian 16-bit payload size,
// that many payload bytes and a checksum byte equal to the XOR of the id,
// the size bytes and the payload. Every payload byte comes out as a word of
// kind 0 with its index; the checksum byte ends the frame with a word of kind
// 1 (good) or 2 (mismatch) and last set. A declared size above max_payload
// (reset value 1024, written through the csr port, sampled on the size low
// byte) ends the frame at once with a word of kind 3 and the hunt restarts.
// A wrong second sync byte restarts the hunt without being taken as a new
// first sync byte. Throughput is one received word per clock cycle, bytes
// that yield no result included, while no result word waits with rsp ready
// low. A result word passes the input register and the result register,
// with the parse logic between them, before it shows on the rsp port.
// While a result word waits with rsp ready low, no byte is parsed, so the
// input takes at most one more word and then stalls. The csr port is always
// ready and must be written only while no frame is in progress.
module sync_length_xor_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   sxfr_req_if.sink   req_port,
   sxfr_rsp_if.source rsp_port,
   sxfr_csr_if.sink   csr_port
);
   import sxfr_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       step;
   logic       res_valid;
   rsp_type    res;

   // A held byte is parsed as soon as the result register can take its word.
   assign step = byte_valid && out_free;

   assign csr_port.ready = 1'b1;

   sxfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .drain      (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   sxfr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (byte_data),
      .csr_write (csr_port.valid),
      .csr_data  (csr_port.max_payload),
      .res_valid (res_valid),
      .res       (res)
   );

   sxfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .free       (out_free),
      .rsp        (rsp_port)
   );

endmodule
